[rtl/core/flat_json_object_tokenizer_core_macros.svh]
// Assertion macros shared by the flat JSON object tokenizer core.
// No dependencies; included by the modules that carry assertions.
`ifndef FLAT_JSON_OBJECT_TOKENIZER_CORE_MACROS_SVH
`define FLAT_JSON_OBJECT_TOKENIZER_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define FJOT_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define FJOT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define FJOT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/fjot_pkg.sv]
// Shared types and constants of the flat JSON object tokenizer core.
// No dependencies; compiled before every other file of the core.
package fjot_pkg;

   // Default signed integer range checked by the number parser.
   localparam int INT_WIDTH_DEF = 32;

   // Response group queue between the parser and the response serializer.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      EV_KEY_BYTE = 3'd0,
      EV_STR_BYTE = 3'd1,
      EV_KEY_END  = 3'd2,
      EV_STR_END  = 3'd3,
      EV_INT      = 3'd4,
      EV_ACCEPT   = 3'd5,
      EV_REJECT   = 3'd6
   } event_type;

   // All responses caused by one request: one event code, one to three
   // bytes (only multi-byte UTF-8 uses more than one), and the integer.
   typedef struct packed {
      event_type       ev;
      logic [1:0]      cnt;
      logic [2:0][7:0] bytes;
      logic [31:0]     ival;
   } group_type;

endpackage

[rtl/core/fjot_if.sv]
// Request and response channel interfaces of the flat JSON object tokenizer.
// No dependencies; a transfer happens when valid and ready are both high.
interface fjot_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] data_byte;

   modport source (output valid, output cmd, output data_byte, input ready);
   modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface fjot_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         event_res;
   logic [7:0]         byte_value;
   logic signed [31:0] int_value;
   logic               last;

   modport source (output valid, output event_res, output byte_value,
                   output int_value, output last, input ready);
   modport sink   (input valid, input event_res, input byte_value,
                   input int_value, input last, output ready);
endinterface

[rtl/core/fjot_front.sv]
// Parser front end: accepts requests, tracks the JSON grammar and builds
// response groups. Depends on fjot_pkg, fjot_if.sv and the macros header.
`include "flat_json_object_tokenizer_core_macros.svh"

module fjot_front #(
   parameter int INT_WIDTH = fjot_pkg::INT_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   fjot_req_if.sink            req,
   input  logic                q_ready,
   output logic                push_valid,
   output fjot_pkg::group_type push_grp
);
   import fjot_pkg::*;

   localparam int CHK_W = INT_WIDTH + 4;
   localparam int EXT_W = (INT_WIDTH > 32) ? INT_WIDTH : 32;

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;

   localparam logic [2:0] ESC_NONE  = 3'd0;
   localparam logic [2:0] ESC_SLASH = 3'd1;
   localparam logic [2:0] ESC_HEX0  = 3'd2;
   localparam logic [2:0] ESC_HEX3  = 3'd5;

   typedef enum logic [3:0] {
      PH_OPEN, PH_FIRST, PH_STRING, PH_COLON, PH_VALUE,
      PH_INT, PH_AFTER, PH_KEY, PH_DONE, PH_ERROR
   } phase_type;

   function automatic logic is_ws(input logic [7:0] b);
      return (b inside {8'h20, [8'h09:8'h0D]});
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b inside {[8'h30:8'h39]});
   endfunction

   // Returns {valid, nibble}.
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] r;
      r = '0;
      if (b inside {[8'h30:8'h39]}) begin
         r = {1'b1, b[3:0]};
      end else if ((b inside {[8'h61:8'h66]}) || (b inside {[8'h41:8'h46]})) begin
         r = {1'b1, b[3:0] + 4'd9};
      end
      return r;
   endfunction

   phase_type            phase_ff, phase_in;
   logic [2:0]           esc_ff, esc_in;
   logic [15:0]          cp_ff, cp_in;
   logic                 in_key_ff, in_key_in;
   logic [INT_WIDTH-1:0] mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic                 digit_ff, digit_in;

   logic                 accept;
   logic [7:0]           b;
   logic [4:0]           hex_res;
   logic [15:0]          cp_new;
   event_type            byte_ev;
   logic [CHK_W-1:0]     mag_w, chk_sum, lim;
   logic                 overflow;
   logic [EXT_W-1:0]     mag_ext, int_ext;

   assign req.ready = q_ready;
   assign accept    = req.valid && q_ready;
   assign b         = req.data_byte;
   assign hex_res   = hex_decode(b);
   assign cp_new    = {cp_ff[11:0], hex_res[3:0]};
   assign byte_ev   = in_key_ff ? EV_KEY_BYTE : EV_STR_BYTE;

   // Range check: magnitude*10 + digit must not pass the signed limit.
   assign mag_w    = CHK_W'(mag_ff);
   assign chk_sum  = (mag_w << 3) + (mag_w << 1) + CHK_W'(b[3:0]);
   assign lim      = (CHK_W'(1) << (INT_WIDTH - 1)) - CHK_W'(!neg_ff);
   assign overflow = chk_sum > lim;

   assign mag_ext = EXT_W'(mag_ff);
   assign int_ext = neg_ff ? (~mag_ext + EXT_W'(1)) : mag_ext;

   always_comb begin
      phase_in   = phase_ff;
      esc_in     = esc_ff;
      cp_in      = cp_ff;
      in_key_in  = in_key_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      digit_in   = digit_ff;
      push_valid = 1'b0;
      push_grp   = '0;
      if (accept) begin
         if (req.cmd) begin
            push_valid   = 1'b1;
            push_grp.ev  = (phase_ff == PH_DONE) ? EV_ACCEPT : EV_REJECT;
            push_grp.cnt = 2'd1;
            phase_in     = PH_OPEN;
            esc_in       = ESC_NONE;
            cp_in        = '0;
            in_key_in    = 1'b0;
            mag_in       = '0;
            neg_in       = 1'b0;
            digit_in     = 1'b0;
         end else begin
            case (phase_ff)
               PH_OPEN: begin
                  if (b == CH_LBRACE) phase_in = PH_FIRST;
                  else if (!is_ws(b)) phase_in = PH_ERROR;
               end
               PH_FIRST, PH_KEY: begin
                  if (b == CH_RBRACE && phase_ff == PH_FIRST) begin
                     phase_in = PH_DONE;
                  end else if (b == CH_QUOTE) begin
                     phase_in  = PH_STRING;
                     in_key_in = 1'b1;
                     esc_in    = ESC_NONE;
                     cp_in     = '0;
                  end else if (!is_ws(b)) begin
                     phase_in = PH_ERROR;
                  end
               end
               PH_STRING: begin
                  if (esc_ff == ESC_NONE) begin
                     if (b == CH_QUOTE) begin
                        push_valid   = 1'b1;
                        push_grp.ev  = in_key_ff ? EV_KEY_END : EV_STR_END;
                        push_grp.cnt = 2'd1;
                        phase_in     = in_key_ff ? PH_COLON : PH_AFTER;
                     end else if (b < 8'h20) begin
                        phase_in = PH_ERROR;
                     end else if (b == CH_BSLASH) begin
                        esc_in = ESC_SLASH;
                     end else begin
                        push_valid        = 1'b1;
                        push_grp.ev       = byte_ev;
                        push_grp.cnt      = 2'd1;
                        push_grp.bytes[0] = b;
                     end
                  end else if (esc_ff == ESC_SLASH) begin
                     esc_in            = ESC_NONE;
                     push_grp.ev       = byte_ev;
                     push_grp.cnt      = 2'd1;
                     push_valid        = 1'b1;
                     case (b)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: push_grp.bytes[0] = b;
                        CH_LOW_B: push_grp.bytes[0] = 8'h08;
                        CH_LOW_F: push_grp.bytes[0] = 8'h0C;
                        CH_LOW_N: push_grp.bytes[0] = 8'h0A;
                        CH_LOW_R: push_grp.bytes[0] = 8'h0D;
                        CH_LOW_T: push_grp.bytes[0] = 8'h09;
                        CH_LOW_U: begin
                           push_valid = 1'b0;
                           esc_in     = ESC_HEX0;
                           cp_in      = '0;
                        end
                        default: begin
                           push_valid = 1'b0;
                           phase_in   = PH_ERROR;
                        end
                     endcase
                  end else begin
                     if (!hex_res[4]) begin
                        phase_in = PH_ERROR;
                     end else if (esc_ff != ESC_HEX3) begin
                        esc_in = esc_ff + 3'd1;
                        cp_in  = cp_new;
                     end else begin
                        esc_in      = ESC_NONE;
                        cp_in       = '0;
                        push_grp.ev = byte_ev;
                        if (cp_new >= 16'hD800 && cp_new <= 16'hDFFF) begin
                           phase_in = PH_ERROR;
                        end else if (cp_new <= 16'h007F) begin
                           push_valid        = 1'b1;
                           push_grp.cnt      = 2'd1;
                           push_grp.bytes[0] = cp_new[7:0];
                        end else if (cp_new <= 16'h07FF) begin
                           push_valid        = 1'b1;
                           push_grp.cnt      = 2'd2;
                           push_grp.bytes[0] = {3'b110, cp_new[10:6]};
                           push_grp.bytes[1] = {2'b10, cp_new[5:0]};
                        end else begin
                           push_valid        = 1'b1;
                           push_grp.cnt      = 2'd3;
                           push_grp.bytes[0] = {4'b1110, cp_new[15:12]};
                           push_grp.bytes[1] = {2'b10, cp_new[11:6]};
                           push_grp.bytes[2] = {2'b10, cp_new[5:0]};
                        end
                     end
                  end
               end
               PH_COLON: begin
                  if (b == CH_COLON) phase_in = PH_VALUE;
                  else if (!is_ws(b)) phase_in = PH_ERROR;
               end
               PH_VALUE: begin
                  if (b == CH_QUOTE) begin
                     phase_in  = PH_STRING;
                     in_key_in = 1'b0;
                     esc_in    = ESC_NONE;
                     cp_in     = '0;
                  end else if (b == CH_MINUS) begin
                     phase_in = PH_INT;
                     mag_in   = '0;
                     neg_in   = 1'b1;
                     digit_in = 1'b0;
                  end else if (is_digit(b)) begin
                     phase_in = PH_INT;
                     mag_in   = INT_WIDTH'(b[3:0]);
                     neg_in   = 1'b0;
                     digit_in = 1'b1;
                  end else if (!is_ws(b)) begin
                     phase_in = PH_ERROR;
                  end
               end
               PH_INT: begin
                  if (is_digit(b)) begin
                     if (overflow) begin
                        phase_in = PH_ERROR;
                     end else begin
                        mag_in   = chk_sum[INT_WIDTH-1:0];
                        digit_in = 1'b1;
                     end
                  end else if (!digit_ff) begin
                     phase_in = PH_ERROR;
                  end else begin
                     // The terminating byte reports the number, then is
                     // judged as the byte after a value.
                     push_valid    = 1'b1;
                     push_grp.ev   = EV_INT;
                     push_grp.cnt  = 2'd1;
                     push_grp.ival = int_ext[31:0];
                     if (is_ws(b)) phase_in = PH_AFTER;
                     else if (b == CH_RBRACE) phase_in = PH_DONE;
                     else if (b == CH_COMMA) phase_in = PH_KEY;
                     else phase_in = PH_ERROR;
                  end
               end
               PH_AFTER: begin
                  if (b == CH_RBRACE) phase_in = PH_DONE;
                  else if (b == CH_COMMA) phase_in = PH_KEY;
                  else if (!is_ws(b)) phase_in = PH_ERROR;
               end
               PH_DONE: begin
                  if (!is_ws(b)) phase_in = PH_ERROR;
               end
               PH_ERROR: begin
                  phase_in = PH_ERROR;
               end
               default: begin
                  phase_in = PH_ERROR;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_OPEN;
         esc_ff    <= ESC_NONE;
         cp_ff     <= '0;
         in_key_ff <= 1'b0;
         mag_ff    <= '0;
         neg_ff    <= 1'b0;
         digit_ff  <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         esc_ff    <= esc_in;
         cp_ff     <= cp_in;
         in_key_ff <= in_key_in;
         mag_ff    <= mag_in;
         neg_ff    <= neg_in;
         digit_ff  <= digit_in;
      end
   end

   `FJOT_ASSERT_SAME(a_push_needs_accept, clock, reset, push_valid, accept, "group pushed without an accepted request")
   `FJOT_ASSERT_SAME(a_error_silent, clock, reset, (phase_ff == PH_ERROR) && accept && !req.cmd, !push_valid, "response produced in the error state")
   `FJOT_ASSERT_NEXT(a_end_restarts, clock, reset, accept && req.cmd, (phase_ff == PH_OPEN) && (esc_ff == ESC_NONE), "end of body did not restart the parser")

endmodule

[rtl/core/fjot_queue.sv]
// Short queue of response groups between the parser and the serializer.
// Depends on fjot_pkg and the macros header.
`include "flat_json_object_tokenizer_core_macros.svh"

module fjot_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fjot_pkg::group_type push_grp,
   output logic                ready,
   input  logic                pop,
   output logic                head_valid,
   output fjot_pkg::group_type head_grp
);
   import fjot_pkg::*;

   group_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign ready      = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_grp   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) count_in = count_ff + QCNT_W'(1);
      else if (pop && !push) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_grp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `FJOT_ASSERT_SAME(a_no_push_full, clock, reset, push, ready,
                     "group pushed into a full queue")
   `FJOT_ASSERT_SAME(a_no_pop_empty, clock, reset, pop, head_valid,
                     "group popped from an empty queue")
   `FJOT_ASSERT_SAME(a_empty_ptrs, clock, reset, count_ff == '0, rd_ptr_ff == wr_ptr_ff,
                     "empty queue with unequal pointers")

endmodule

[rtl/core/fjot_back.sv]
// Response serializer: sends the responses of the head group one per cycle
// while ready is high. Depends on fjot_pkg and fjot_if.sv.
module fjot_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  fjot_pkg::group_type head_grp,
   output logic                pop,
   fjot_rsp_if.source          rsp
);
   import fjot_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       final_one;
   logic       take;

   assign final_one = idx_ff == (head_grp.cnt - 2'd1);
   assign take      = head_valid && rsp.ready;
   assign pop       = take && final_one;

   assign rsp.valid      = head_valid;
   assign rsp.event_res  = head_grp.ev;
   assign rsp.int_value  = head_grp.ival;
   assign rsp.last       = final_one;
   assign rsp.byte_value = (idx_ff == 2'd0) ? head_grp.bytes[0] :
                           (idx_ff == 2'd1) ? head_grp.bytes[1] : head_grp.bytes[2];

   always_comb begin
      idx_in = idx_ff;
      if (take) idx_in = final_one ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

[rtl/core/flat_json_object_tokenizer_core.sv]
// Top level of the flat JSON object tokenizer core.
// Depends on fjot_pkg, fjot_if.sv, fjot_front, fjot_queue and fjot_back.
//
// This core checks that a request stream of body bytes forms one flat JSON
// object whose values are strings or signed decimal integers, and streams out
// decoded key bytes, string bytes, key and string end marks, integers, and a
// final accept or reject answer for each end-of-body request. A request is
// accepted in the cycle it is offered whenever the response group queue has
// room, so the core takes one request per cycle as long as each request
// yields at most one response and no response stalls. A request that decodes
// a \u escape into two or three UTF-8 bytes yields that many responses, and
// the response port, which moves one response per cycle unless stalled, then
// sets the pace; the four-entry group queue absorbs such bursts so the request
// side keeps flowing. The queue registers each group, so no response appears
// in the cycle its request is accepted. After an error, body bytes produce
// nothing until the next end-of-body request, which answers reject and
// restarts the parser. INT_WIDTH sets the signed range that integers must
// fit; the reported value is always the low 32 bits of two's complement.
module flat_json_object_tokenizer_core #(
   parameter int INT_WIDTH = fjot_pkg::INT_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   fjot_req_if.sink   req_chan,
   fjot_rsp_if.source rsp_chan
);
   import fjot_pkg::*;

   // Parser output: one group per request that produces any response.
   logic      push_valid;
   group_type push_grp;
   logic      q_ready;

   // Queue head toward the serializer.
   logic      head_valid;
   group_type head_grp;
   logic      pop;

   // The front end owns the grammar state and accepts requests while the
   // queue has room.
   fjot_front #(
      .INT_WIDTH (INT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .q_ready    (q_ready),
      .push_valid (push_valid),
      .push_grp   (push_grp)
   );

   // The queue holds whole response groups so the two sides stall apart.
   fjot_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_grp   (push_grp),
      .ready      (q_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_grp   (head_grp)
   );

   // The back end sends each group's responses in order and flags the last.
   fjot_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_grp   (head_grp),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule

[test/flat_json_object_tokenizer_core_tb.sv]
// Self-checking testbench for the flat JSON object tokenizer core.
// Depends on fjot_pkg (rtl/core/fjot_pkg.sv), the channel interfaces in
// rtl/core/fjot_if.sv, and the core itself.
module flat_json_object_tokenizer_core_tb;
   import fjot_pkg::*;

   localparam int INT_BITS         = INT_WIDTH_DEF;
   localparam int TARGET_REQUESTS  = 430;
   localparam int LONG_HOLD_CYCLES = 64;
   localparam int TAIL_CYCLES      = 20;
   localparam int WATCHDOG_LIMIT   = 1000;

   // Parser phases of the predictor, one per position in the object grammar.
   typedef enum logic [3:0] {
      ST_BRACE,
      ST_FIRST_KEY,
      ST_STRING,
      ST_COLON,
      ST_VALUE,
      ST_NUMBER,
      ST_AFTER_VALUE,
      ST_NEXT_KEY,
      ST_CLOSED,
      ST_FAILED
   } parse_state_type;

   typedef enum logic {
      CMD_BYTE = 1'b0,
      CMD_END  = 1'b1
   } req_cmd_type;

   // Ways in which a generated object body is damaged. The string flaws come
   // first and the integer flaws next so that each group is a range.
   typedef enum int {
      FLAW_NONE,
      FLAW_SURROGATE,
      FLAW_CONTROL,
      FLAW_BAD_ESCAPE,
      FLAW_BAD_HEX,
      FLAW_OVERFLOW,
      FLAW_LONE_MINUS,
      FLAW_INT_TRAILER,
      FLAW_AFTER_CLOSE,
      FLAW_TRUNCATE,
      FLAW_SUBSTITUTE,
      FLAW_DROP_BYTE
   } flaw_type;

   typedef struct {
      req_cmd_type cmd;
      logic [7:0]  data;
      int          gap;
   } body_request_type;

   typedef struct {
      event_type   ev;
      logic [7:0]  data;
      logic [31:0] ival;
      logic        last;
   } token_event_type;

   logic clock = 1'b0;
   logic reset;

   fjot_req_if req_bus ();
   fjot_rsp_if rsp_bus ();

   flat_json_object_tokenizer_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // The clock runs with a period of 8 time units.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Tokenizer predictor. It mirrors the parser state and, for every request
   // the core accepts, appends the responses that request must produce to
   // expected_tokens, with last set on the final one.
   // ---------------------------------------------------------------------
   parse_state_type tk_state;
   int              tk_esc;      // 0 idle, 1 after backslash, 2..5 hex digits due
   logic [15:0]     tk_code;
   logic            tk_in_key;
   logic [63:0]     tk_mag;
   logic            tk_neg;
   logic            tk_digit;

   token_event_type step_tokens[$];
   token_event_type expected_tokens[$];

   function automatic bit is_space(logic [7:0] b);
      return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic int hex_value(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b) - 48;
      if (b >= "a" && b <= "f") return int'(b) - 87;
      if (b >= "A" && b <= "F") return int'(b) - 55;
      return -1;
   endfunction

   task automatic emit(event_type ev, logic [7:0] data, logic [31:0] ival);
      token_event_type tok;
      tok.ev   = ev;
      tok.data = data;
      tok.ival = ival;
      tok.last = 1'b0;
      step_tokens.insert(step_tokens.size(), tok);
   endtask

   task automatic clear_tokenizer();
      tk_state  = ST_BRACE;
      tk_esc    = 0;
      tk_code   = 16'h0000;
      tk_in_key = 1'b0;
      tk_mag    = 64'd0;
      tk_neg    = 1'b0;
      tk_digit  = 1'b0;
   endtask

   task automatic open_string(logic is_key);
      tk_in_key = is_key;
      tk_esc    = 0;
      tk_code   = 16'h0000;
      tk_state  = ST_STRING;
   endtask

   // One byte inside a key or a string value, including escape decoding.
   task automatic string_step(logic [7:0] b);
      event_type data_ev;
      int        h;
      data_ev = tk_in_key ? EV_KEY_BYTE : EV_STR_BYTE;
      if (tk_esc == 0) begin
         if (b == "\"") begin
            if (tk_in_key) begin
               emit(EV_KEY_END, 8'h00, 32'd0);
               tk_state = ST_COLON;
            end else begin
               emit(EV_STR_END, 8'h00, 32'd0);
               tk_state = ST_AFTER_VALUE;
            end
         end else if (b < 8'h20) begin
            tk_state = ST_FAILED;
         end else if (b == "\\") begin
            tk_esc = 1;
         end else begin
            emit(data_ev, b, 32'd0);
         end
      end else if (tk_esc == 1) begin
         tk_esc = 0;
         case (b)
            "\"", "\\", "/": emit(data_ev, b, 32'd0);
            "b": emit(data_ev, 8'h08, 32'd0);
            "f": emit(data_ev, 8'h0C, 32'd0);
            "n": emit(data_ev, 8'h0A, 32'd0);
            "r": emit(data_ev, 8'h0D, 32'd0);
            "t": emit(data_ev, 8'h09, 32'd0);
            "u": begin
               tk_esc  = 2;
               tk_code = 16'h0000;
            end
            default: tk_state = ST_FAILED;
         endcase
      end else begin
         h = hex_value(b);
         if (h < 0) begin
            tk_state = ST_FAILED;
         end else begin
            tk_code = {tk_code[11:0], h[3:0]};
            if (tk_esc < 5) begin
               tk_esc++;
            end else begin
               // Fourth hex digit: the code point is complete.
               tk_esc = 0;
               if (tk_code >= 16'hD800 && tk_code <= 16'hDFFF) begin
                  tk_state = ST_FAILED;
               end else if (tk_code <= 16'h007F) begin
                  emit(data_ev, tk_code[7:0], 32'd0);
               end else if (tk_code <= 16'h07FF) begin
                  emit(data_ev, {3'b110, tk_code[10:6]}, 32'd0);
                  emit(data_ev, {2'b10, tk_code[5:0]}, 32'd0);
               end else begin
                  emit(data_ev, {4'b1110, tk_code[15:12]}, 32'd0);
                  emit(data_ev, {2'b10, tk_code[11:6]}, 32'd0);
                  emit(data_ev, {2'b10, tk_code[5:0]}, 32'd0);
               end
               tk_code = 16'h0000;
            end
         end
      end
   endtask

   task automatic start_number(logic neg);
      tk_mag   = 64'd0;
      tk_neg   = neg;
      tk_digit = 1'b0;
      tk_state = ST_NUMBER;
   endtask

   // Adds one decimal digit, or fails if the value would leave the signed
   // INT_BITS range (the negative side reaches one further).
   task automatic number_digit(int d);
      logic [63:0] limit;
      limit = (64'd1 << (INT_BITS - 1)) - (tk_neg ? 64'd0 : 64'd1);
      if (tk_mag > (limit - 64'(d)) / 64'd10) begin
         tk_state = ST_FAILED;
      end else begin
         tk_mag   = tk_mag * 64'd10 + 64'(d);
         tk_digit = 1'b1;
      end
   endtask

   task automatic after_value(logic [7:0] b);
      if (!is_space(b)) begin
         if (b == "}") tk_state = ST_CLOSED;
         else if (b == ",") tk_state = ST_NEXT_KEY;
         else tk_state = ST_FAILED;
      end
   endtask

   task automatic tokenize_request(req_cmd_type cmd, logic [7:0] b);
      logic [63:0]     value;
      token_event_type tok;
      step_tokens.delete();
      if (cmd == CMD_END) begin
         if (tk_state == ST_CLOSED) emit(EV_ACCEPT, 8'h00, 32'd0);
         else emit(EV_REJECT, 8'h00, 32'd0);
         clear_tokenizer();
      end else begin
         case (tk_state)
            ST_BRACE: begin
               if (b == "{") tk_state = ST_FIRST_KEY;
               else if (!is_space(b)) tk_state = ST_FAILED;
            end
            ST_FIRST_KEY: begin
               if (b == "}") tk_state = ST_CLOSED;
               else if (b == "\"") open_string(1'b1);
               else if (!is_space(b)) tk_state = ST_FAILED;
            end
            ST_NEXT_KEY: begin
               if (b == "\"") open_string(1'b1);
               else if (!is_space(b)) tk_state = ST_FAILED;
            end
            ST_STRING: string_step(b);
            ST_COLON: begin
               if (b == ":") tk_state = ST_VALUE;
               else if (!is_space(b)) tk_state = ST_FAILED;
            end
            ST_VALUE: begin
               if (b == "\"") begin
                  open_string(1'b0);
               end else if (b == "-") begin
                  start_number(1'b1);
               end else if (is_digit(b)) begin
                  start_number(1'b0);
                  number_digit(int'(b) - 48);
               end else if (!is_space(b)) begin
                  tk_state = ST_FAILED;
               end
            end
            ST_NUMBER: begin
               if (is_digit(b)) begin
                  number_digit(int'(b) - 48);
               end else if (!tk_digit) begin
                  tk_state = ST_FAILED;
               end else begin
                  // The byte after the number reports it, then counts as the
                  // byte following a value.
                  value = tk_neg ? (64'd0 - tk_mag) : tk_mag;
                  emit(EV_INT, 8'h00, value[31:0]);
                  tk_state = ST_AFTER_VALUE;
                  after_value(b);
               end
            end
            ST_AFTER_VALUE: after_value(b);
            ST_CLOSED: begin
               if (!is_space(b)) tk_state = ST_FAILED;
            end
            default: tk_state = ST_FAILED;
         endcase
      end
      foreach (step_tokens[i]) begin
         tok      = step_tokens[i];
         tok.last = (i == step_tokens.size() - 1);
         expected_tokens.insert(expected_tokens.size(), tok);
      end
   endtask

   // ---------------------------------------------------------------------
   // Request driver. It pops pending requests, waits out each one's drawn
   // gap, and holds the request on the channel until the core takes it.
   // Prediction happens at the very edge where the core accepts a request.
   // ---------------------------------------------------------------------
   body_request_type pending_requests[$];
   body_request_type next_req;
   body_request_type on_wire;
   bit               next_loaded;
   int               next_wait;
   int               requests_taken = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.cmd       <= CMD_BYTE;
         req_bus.data_byte <= 8'h00;
         next_loaded = 1'b0;
         next_wait   = 0;
         clear_tokenizer();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            tokenize_request(on_wire.cmd, on_wire.data);
            requests_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (!next_loaded && pending_requests.size() > 0) begin
               next_req    = pending_requests.pop_front();
               next_wait   = next_req.gap;
               next_loaded = 1'b1;
            end
            if (next_loaded && next_wait == 0) begin
               req_bus.valid     <= 1'b1;
               req_bus.cmd       <= next_req.cmd;
               req_bus.data_byte <= next_req.data;
               on_wire     = next_req;
               next_loaded = 1'b0;
            end else begin
               req_bus.valid <= 1'b0;
               if (next_loaded) next_wait--;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor. Every accepted response is checked field by field
   // against the oldest expectation. After each response the receiver draws
   // a random stall, except in every third band of 50 responses, where it
   // draws none. Twice in the run it holds ready low for a long stretch so that
   // the group queue fills and the core stops taking requests while the driver
   // keeps offering them.
   // ---------------------------------------------------------------------
   int mismatch_count  = 0;
   int tokens_seen     = 0;
   int accepts_seen    = 0;
   int rejects_seen    = 0;
   int integers_seen   = 0;
   int rsp_stall_left  = 0;
   int rsp_hold_left   = 0;

   task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      token_event_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall_left = 0;
         rsp_hold_left  = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            tokens_seen++;
            if (rsp_bus.event_res == EV_ACCEPT) accepts_seen++;
            if (rsp_bus.event_res == EV_REJECT) rejects_seen++;
            if (rsp_bus.event_res == EV_INT) integers_seen++;
            if (expected_tokens.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual event %0d",
                        $time, rsp_bus.event_res);
               mismatch_count++;
            end else begin
               want = expected_tokens.pop_front();
               compare_field("event_res", 32'(want.ev), 32'(rsp_bus.event_res));
               compare_field("byte_value", 32'(want.data), 32'(rsp_bus.byte_value));
               compare_field("int_value", want.ival, rsp_bus.int_value);
               compare_field("last", 32'(want.last), 32'(rsp_bus.last));
            end
            if (((tokens_seen / 50) % 3) == 2) rsp_stall_left = 0;
            else rsp_stall_left = $urandom_range(0, 9);
            if (tokens_seen == 40 || tokens_seen == 260) rsp_hold_left = LONG_HOLD_CYCLES;
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog: too many cycles in a row without any handshake ends the run.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d responses still expected",
                     $time, idle_cycles, expected_tokens.size());
            $display("flat_json_object_tokenizer_core test failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Body generation. Bytes of one body are collected in body_bytes and then
   // queued as requests, all with gaps of the current sender mode.
   // ---------------------------------------------------------------------
   logic [7:0] body_bytes[$];
   bit         calm_sender;
   int         items_queued = 0;

   task automatic add_byte(logic [7:0] b);
      body_bytes.insert(body_bytes.size(), b);
   endtask

   task automatic queue_request(req_cmd_type cmd, logic [7:0] data);
      body_request_type r;
      r.cmd  = cmd;
      r.data = data;
      r.gap  = calm_sender ? 0 : $urandom_range(0, 9);
      pending_requests.insert(pending_requests.size(), r);
      items_queued++;
   endtask

   // Queues the collected body followed by an end-of-body request.
   task automatic queue_body();
      foreach (body_bytes[i]) queue_request(CMD_BYTE, body_bytes[i]);
      body_bytes.delete();
      queue_request(CMD_END, 8'h00);
   endtask

   task automatic put_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   // Usually no whitespace, sometimes one or two of the six allowed bytes.
   task automatic put_ws();
      int n;
      int k;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 5);
         add_byte(k == 5 ? 8'h20 : 8'h09 + k[7:0]);
      end
   endtask

   function automatic logic [7:0] hex_char(logic [3:0] nib);
      if (nib < 10) return 8'h30 + nib;
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
   endfunction

   task automatic put_unicode(logic [15:0] cp);
      put_text("\\u");
      add_byte(hex_char(cp[15:12]));
      add_byte(hex_char(cp[11:8]));
      add_byte(hex_char(cp[7:4]));
      add_byte(hex_char(cp[3:0]));
   endtask

   // A legal code point: an edge of a UTF-8 length class, or a random one
   // of one, two or three bytes, with surrogates moved out of the way.
   function automatic logic [15:0] pick_code_point();
      logic [15:0] cp;
      case ($urandom_range(0, 3))
         0: begin
            case ($urandom_range(0, 7))
               0: cp = 16'h0000;
               1: cp = 16'h007F;
               2: cp = 16'h0080;
               3: cp = 16'h07FF;
               4: cp = 16'h0800;
               5: cp = 16'hD7FF;
               6: cp = 16'hE000;
               default: cp = 16'hFFFF;
            endcase
         end
         1: cp = 16'($urandom_range(16'h0000, 16'h007F));
         2: cp = 16'($urandom_range(16'h0080, 16'h07FF));
         default: begin
            cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            if (cp >= 16'hD800 && cp <= 16'hDFFF) cp = cp ^ 16'h2000;
         end
      endcase
      return cp;
   endfunction

   task automatic put_string_piece();
      string      escapes;
      logic [7:0] b;
      escapes = "\"\\/bfnrt";
      case ($urandom_range(0, 4))
         0, 1: begin
            b = 8'($urandom_range(8'h20, 8'h7E));
            if (b == "\"" || b == "\\") b = "a";
            add_byte(b);
         end
         2: add_byte(8'($urandom_range(8'h80, 8'hFF)));
         3: begin
            add_byte("\\");
            add_byte(escapes[$urandom_range(0, 7)]);
         end
         default: put_unicode(pick_code_point());
      endcase
   endtask

   function automatic bit is_escape_letter(logic [7:0] b);
      return b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" ||
             b == "n" || b == "r" || b == "t" || b == "u";
   endfunction

   task automatic put_string_flaw(flaw_type flaw);
      logic [7:0] b;
      int         n;
      case (flaw)
         FLAW_SURROGATE: put_unicode(16'hD800 | 16'($urandom_range(0, 16'h07FF)));
         FLAW_CONTROL: add_byte(8'($urandom_range(8'h00, 8'h1F)));
         FLAW_BAD_ESCAPE: begin
            add_byte("\\");
            b = 8'($urandom_range(0, 255));
            while (is_escape_letter(b)) b = 8'($urandom_range(0, 255));
            add_byte(b);
         end
         default: begin
            // A \u escape cut short by a byte that is not a hex digit.
            put_text("\\u");
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) add_byte(hex_char(4'($urandom_range(0, 15))));
            b = 8'($urandom_range(0, 255));
            while (hex_value(b) >= 0) b = 8'($urandom_range(0, 255));
            add_byte(b);
         end
      endcase
   endtask

   task automatic put_string(flaw_type flaw);
      int pieces;
      int flaw_at;
      pieces  = $urandom_range(0, 3);
      flaw_at = $urandom_range(0, pieces);
      add_byte("\"");
      for (int i = 0; i <= pieces; i++) begin
         if (i == flaw_at && flaw != FLAW_NONE) put_string_flaw(flaw);
         if (i < pieces) put_string_piece();
      end
      add_byte("\"");
   endtask

   task automatic put_int(flaw_type flaw);
      longint v;
      string  digits;
      case (flaw)
         FLAW_OVERFLOW: begin
            case ($urandom_range(0, 2))
               0: v = 64'sd2147483648 + longint'($urandom_range(0, 1000));
               1: v = -64'sd2147483649 - longint'($urandom_range(0, 1000));
               default: v = 64'sd10000000000 + longint'($urandom);
            endcase
            digits = $sformatf("%0d", v);
         end
         FLAW_LONE_MINUS: digits = "-";
         default: begin
            case ($urandom_range(0, 3))
               0: begin
                  v = $urandom_range(0, 99);
                  if ($urandom_range(0, 1)) v = -v;
                  digits = $sformatf("%0d", v);
               end
               1: begin
                  case ($urandom_range(0, 3))
                     0: digits = "2147483647";
                     1: digits = "-2147483648";
                     2: digits = "0";
                     default: digits = "-0";
                  endcase
               end
               2: begin
                  v = longint'(int'($urandom));
                  digits = $sformatf("%0d", v);
               end
               default: begin
                  digits = $sformatf("00%0d", $urandom_range(0, 999));
                  if ($urandom_range(0, 1)) digits = {"-", digits};
               end
            endcase
         end
      endcase
      put_text(digits);
      // A letter right after the digits still ends the number.
      if (flaw == FLAW_INT_TRAILER) add_byte(8'($urandom_range(8'h61, 8'h7A)));
   endtask

   // One object body, well formed when flaw is FLAW_NONE and otherwise
   // damaged in the given way, followed by its end-of-body request.
   task automatic build_object(flaw_type flaw);
      int         pairs;
      int         bad_pair;
      int         pos;
      bit         str_flaw;
      bit         int_flaw;
      logic [7:0] b;
      str_flaw = flaw >= FLAW_SURROGATE && flaw <= FLAW_BAD_HEX;
      int_flaw = flaw >= FLAW_OVERFLOW && flaw <= FLAW_INT_TRAILER;
      pairs    = $urandom_range((str_flaw || int_flaw) ? 1 : 0, 3);
      bad_pair = (pairs > 0) ? $urandom_range(0, pairs - 1) : 0;
      put_ws();
      add_byte("{");
      for (int i = 0; i < pairs; i++) begin
         if (i > 0) begin
            put_ws();
            add_byte(",");
         end
         put_ws();
         put_string(FLAW_NONE);
         put_ws();
         add_byte(":");
         put_ws();
         if (i == bad_pair && str_flaw) put_string(flaw);
         else if (i == bad_pair && int_flaw) put_int(flaw);
         else if ($urandom_range(0, 1)) put_string(FLAW_NONE);
         else put_int(FLAW_NONE);
      end
      put_ws();
      add_byte("}");
      put_ws();
      case (flaw)
         FLAW_AFTER_CLOSE: begin
            b = 8'($urandom_range(0, 255));
            while (is_space(b)) b = 8'($urandom_range(0, 255));
            add_byte(b);
            put_ws();
         end
         FLAW_TRUNCATE: begin
            pos = $urandom_range(0, body_bytes.size() - 1);
            while (body_bytes.size() > pos) void'(body_bytes.pop_back());
         end
         FLAW_SUBSTITUTE: begin
            pos = $urandom_range(0, body_bytes.size() - 1);
            body_bytes[pos] = 8'($urandom_range(0, 255));
         end
         FLAW_DROP_BYTE: body_bytes.delete($urandom_range(0, body_bytes.size() - 1));
         default: ;
      endcase
      queue_body();
   endtask

   // ---------------------------------------------------------------------
   // Main sequence: reset, a short directed set, then random objects until
   // about TARGET_REQUESTS requests have been queued. Most objects are well
   // formed so that the deep phases of the parser are exercised; the rest
   // carry one flaw each or are plain noise.
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int       pick;
      int       noise_len;
      flaw_type flaw;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: a three-byte UTF-8 key with the largest positive integer,
      // then the empty object, both expected to be accepted.
      calm_sender = 1'b1;
      put_text("{\"\\u20AC\":2147483647}");
      queue_body();
      put_text("{}");
      queue_body();

      while (items_queued < TARGET_REQUESTS) begin
         calm_sender = ($urandom_range(0, 2) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            build_object(FLAW_NONE);
         end else if (pick < 90) begin
            flaw = flaw_type'($urandom_range(FLAW_SURROGATE, FLAW_DROP_BYTE));
            build_object(flaw);
         end else begin
            // Noise: random bytes, sometimes after an opening brace, and
            // sometimes nothing at all before the end of the body.
            noise_len = $urandom_range(0, 6);
            if ($urandom_range(0, 1)) add_byte("{");
            for (int i = 0; i < noise_len; i++) add_byte(8'($urandom_range(0, 255)));
            queue_body();
         end
      end

      while (requests_taken < items_queued || expected_tokens.size() > 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Run covered %0d requests and %0d responses: %0d integers,",
               requests_taken, tokens_seen, integers_seen);
      $display("%0d accepted and %0d rejected bodies, with escapes, UTF-8, integer %s",
               accepts_seen, rejects_seen, "limits, malformed input and long output stalls.");
      if (mismatch_count == 0 && expected_tokens.size() == 0) begin
         $display("flat_json_object_tokenizer_core test passed");
      end else begin
         $display("flat_json_object_tokenizer_core test failed");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/fjot_pkg.sv
rtl/core/fjot_if.sv
rtl/core/fjot_front.sv
rtl/core/fjot_queue.sv
rtl/core/fjot_back.sv
rtl/core/flat_json_object_tokenizer_core.sv
test/flat_json_object_tokenizer_core_tb.sv
